// ===== src/ats_pkg.sv =====
`default_nettype none
package ats_pkg;

  typedef enum logic [2:0] {
    RESP_DONE    = 3'd0,
    RESP_IGNORED = 3'd1,
    RESP_FIRED   = 3'd2,
    RESP_NONE    = 3'd3,
    RESP_HALTED  = 3'd4
  } resp_e;

  typedef enum logic [0:0] {
    KIND_ACTIVATE = 1'b0,
    KIND_TICK     = 1'b1
  } kind_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  localparam int unsigned MaxFires = 8;

  typedef struct packed {
    logic        kind;
    logic [7:0]  event_id;
    logic [30:0] delay_ms;
    logic        periodic;
    logic [31:0] aux_data;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  response;
    logic [7:0]  fired_event;
    logic [31:0] fired_aux;
    logic        last;
  } out_item_t;

  // One table entry as it moves along the row of cells.
  typedef struct packed {
    logic        active;
    logic [30:0] interval;
    logic        periodic;
    logic [7:0]  event_id;
    logic [31:0] aux;
    logic [31:0] due;
  } entry_t;

endpackage
`default_nettype wire

// ===== src/ats_cell.sv =====
`default_nettype none
module ats_cell
  import ats_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   shift_i,
  input  wire logic   load_i,
  input  wire entry_t from_next_i,
  input  wire entry_t tail_i,
  output entry_t      entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (load_i) begin
      entry_d = tail_i;
    end else if (shift_i) begin
      entry_d = from_next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

// ===== src/alarm_table_scheduler.sv =====
// Channel   Direction  Payload      Handshake
// in        input      in_item_t    in_valid_i / in_ready_o
// out       output     out_item_t   out_valid_o / out_ready_i
// cfg       input      9-bit count  cfg_we_i / cfg_wdata_i
//
// The table is a row of SLOTS cells; the first used entries form a queue whose head
// is cell 0. A scan step sends the head to the end of the queue or drops it.
// An item goes through the accept, one scan step per table entry and the final
// result, in that order. A halted or ignored item skips the scan steps.
// A fire waits in a holding register until the next fire sends it on or the scan
// ends and sends it with its last flag set; a step that fires while one is held
// stalls while the result register is full, as does the final result.
// Reset clears the entry count and halted and sets the id count to 256.
`default_nettype none
module alarm_table_scheduler
  import ats_pkg::*;
#(
  parameter int unsigned SLOTS = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_we_i,
  input  wire logic [8:0] cfg_wdata_i
);

  localparam int unsigned CW = $clog2(SLOTS + 1);

  state_e         state_q, state_d;
  in_item_t       item_q;
  logic [8:0]     count_q;
  logic           halted_q, halted_d;
  logic [CW-1:0]  used_q, used_d;
  logic [CW-1:0]  len_q, len_d;    // current queue length during a scan
  logic [CW-1:0]  rem_q, rem_d;    // entries not yet visited in this scan
  logic [3:0]     fires_q, fires_d;
  logic           found_q, found_d;
  out_item_t      out_q, out_d;
  logic           ovalid_q, ovalid_d;
  out_item_t      pend_q, pend_d;
  logic           pend_v_q, pend_v_d;

  logic           step, keep, append;
  entry_t         cells [SLOTS];
  entry_t         head, tail_in, head_mod;

  assign head = cells[0];

  genvar g;
  generate
    for (g = 0; g < SLOTS; g++) begin : g_cell
      entry_t nxt;
      logic   shift_en, load_en;
      if (g == SLOTS - 1) begin : g_tail
        assign nxt = '0;
      end else begin : g_mid
        assign nxt = cells[g+1];
      end
      // The end of the queue takes the kept head; cells behind it hold.
      assign shift_en = step && (CW'(g + 1) < len_q);
      assign load_en  = (step && keep && (CW'(g + 1) == len_q))
                        || (append && (CW'(g) == used_q));
      ats_cell u_cell (
        .clk_i       (clk_i),
        .shift_i     (shift_en),
        .load_i      (load_en),
        .from_next_i (nxt),
        .tail_i      (tail_in),
        .entry_o     (cells[g])
      );
    end
  endgenerate

  logic        in_fire, out_free, ignored, finish, fire_now;
  logic [31:0] now_plus_delay, now_plus_int;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !ovalid_q || out_ready_i;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  assign now_plus_delay = item_q.now_ms + {1'b0, item_q.delay_ms};
  assign now_plus_int   = item_q.now_ms + {1'b0, head.interval};
  assign ignored  = (item_q.kind == KIND_ACTIVATE) && ({1'b0, item_q.event_id} >= count_q);
  assign finish   = halted_q || ignored || (rem_q == '0);
  assign fire_now = (item_q.kind == KIND_TICK) && (fires_q < 4'(MaxFires))
                    && head.active && (item_q.now_ms >= head.due);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 9'd256;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (finish && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    halted_d = halted_q;
    used_d   = used_q;
    len_d    = len_q;
    rem_d    = rem_q;
    fires_d  = fires_q;
    found_d  = found_q;
    pend_d   = pend_q;
    pend_v_d = pend_v_q;
    out_d    = out_q;
    ovalid_d = ovalid_q && !out_ready_i;
    head_mod = head;
    tail_in  = head;
    step     = 1'b0;
    keep     = 1'b0;
    append   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rem_d    = used_q;
          len_d    = used_q;
          fires_d  = '0;
          found_d  = 1'b0;
          pend_v_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (finish) begin
          if (out_free) begin
            ovalid_d = 1'b1;
            if (halted_q) begin
              out_d = '{RESP_HALTED, 8'd0, 32'd0, 1'b1};
            end else if (item_q.kind == KIND_TICK) begin
              if (pend_v_q) begin
                out_d      = pend_q;
                out_d.last = 1'b1;
              end else begin
                out_d = '{RESP_NONE, 8'd0, 32'd0, 1'b1};
              end
              used_d   = len_q;
              pend_v_d = 1'b0;
            end else if (ignored) begin
              out_d = '{RESP_IGNORED, 8'd0, 32'd0, 1'b1};
            end else if (found_q) begin
              out_d = '{RESP_DONE, 8'd0, 32'd0, 1'b1};
            end else if (used_q < CW'(SLOTS)) begin
              out_d   = '{RESP_DONE, 8'd0, 32'd0, 1'b1};
              append  = 1'b1;
              tail_in = '{1'b1, item_q.delay_ms, item_q.periodic, item_q.event_id,
                          item_q.aux_data, now_plus_delay};
              used_d  = used_q + CW'(1);
            end else begin
              halted_d = 1'b1;
              out_d    = '{RESP_HALTED, 8'd0, 32'd0, 1'b1};
            end
          end
        end else if (item_q.kind == KIND_ACTIVATE) begin
          step  = 1'b1;
          keep  = 1'b1;
          rem_d = rem_q - CW'(1);
          if (head.event_id == item_q.event_id) begin
            found_d = 1'b1;
            if (item_q.delay_ms == '0) begin
              head_mod.active = 1'b0;
            end else begin
              head_mod.active   = 1'b1;
              head_mod.interval = item_q.delay_ms;
              head_mod.periodic = item_q.periodic;
              head_mod.aux      = item_q.aux_data;
              head_mod.due      = now_plus_delay;
            end
          end
          tail_in = head_mod;
        end else if (!(fire_now && pend_v_q && !out_free)) begin
          step  = 1'b1;
          keep  = 1'b1;
          rem_d = rem_q - CW'(1);
          if (fire_now) begin
            fires_d = fires_q + 4'd1;
            // A new fire shows that the held one is not the last.
            if (pend_v_q) begin
              out_d    = pend_q;
              ovalid_d = 1'b1;
            end
            pend_d   = '{RESP_FIRED, head.event_id, head.aux, 1'b0};
            pend_v_d = 1'b1;
            if (head.periodic) begin
              head_mod.due = now_plus_int;
            end else begin
              keep  = 1'b0;
              len_d = len_q - CW'(1);
            end
          end
          tail_in = head_mod;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      halted_q <= 1'b0;
      used_q   <= '0;
      len_q    <= '0;
      rem_q    <= '0;
      fires_q  <= '0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      halted_q <= halted_d;
      used_q   <= used_d;
      len_q    <= len_d;
      rem_q    <= rem_d;
      fires_q  <= fires_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
      pend_v_q <= pend_v_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) used_q <= CW'(SLOTS))
    else $error("table count exceeds slot count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= used_q)
    else $error("queue length exceeds table count");
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_fire |=> !in_ready_o)
    else $error("item accepted while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted_q |=> halted_q)
    else $error("halted flag cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while waiting");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`default_nettype none
module tb_top;
  import ats_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumSlots = 8;
  localparam int unsigned RunLimit = 400000;

  typedef struct {
    logic        active;
    logic [30:0] interval;
    logic        periodic;
    logic [7:0]  event_id;
    logic [31:0] aux;
    logic [31:0] due;
  } alarm_t;

  class alarm_scoreboard;
    alarm_t      table_q[$];
    logic        halted;
    logic [8:0]  id_limit;
    out_item_t   pending[$];
    int          errors;

    function void clear();
      table_q.delete();
      pending.delete();
      halted = 1'b0;
      id_limit = 9'd256;
      errors = 0;
    endfunction

    function void push_resp(resp_e r, logic [7:0] ev, logic [31:0] aux, logic last);
      out_item_t o;
      o.response = r;
      o.fired_event = ev;
      o.fired_aux = aux;
      o.last = last;
      pending.push_back(o);
    endfunction

    // Works out the results of one accepted input transfer and updates the table.
    function void note_input(in_item_t it);
      bit     found;
      int     idx;
      int     fires;
      alarm_t a;
      found = 0;
      idx = 0;
      fires = 0;
      if (halted) begin
        push_resp(RESP_HALTED, 8'd0, 32'd0, 1'b1);
        return;
      end
      if (it.kind == KIND_ACTIVATE) begin
        if ({1'b0, it.event_id} >= id_limit) begin
          push_resp(RESP_IGNORED, 8'd0, 32'd0, 1'b1);
          return;
        end
        foreach (table_q[k]) begin
          if (table_q[k].event_id == it.event_id) begin
            found = 1;
            if (it.delay_ms == 31'd0) begin
              table_q[k].active = 1'b0;
            end else begin
              table_q[k].active = 1'b1;
              table_q[k].interval = it.delay_ms;
              table_q[k].periodic = it.periodic;
              table_q[k].aux = it.aux_data;
              table_q[k].due = it.now_ms + {1'b0, it.delay_ms};
            end
          end
        end
        if (!found) begin
          if (table_q.size() >= NumSlots) begin
            halted = 1'b1;
            push_resp(RESP_HALTED, 8'd0, 32'd0, 1'b1);
            return;
          end
          a.active = 1'b1;
          a.interval = it.delay_ms;
          a.periodic = it.periodic;
          a.event_id = it.event_id;
          a.aux = it.aux_data;
          a.due = it.now_ms + {1'b0, it.delay_ms};
          table_q.push_back(a);
        end
        push_resp(RESP_DONE, 8'd0, 32'd0, 1'b1);
        return;
      end
      while (idx < table_q.size() && fires < MaxFires) begin
        if (table_q[idx].active && it.now_ms >= table_q[idx].due) begin
          push_resp(RESP_FIRED, table_q[idx].event_id, table_q[idx].aux, 1'b0);
          fires++;
          if (table_q[idx].periodic) begin
            table_q[idx].due = it.now_ms + {1'b0, table_q[idx].interval};
            idx++;
          end else begin
            table_q.delete(idx);
          end
        end else begin
          idx++;
        end
      end
      if (fires == 0) begin
        push_resp(RESP_NONE, 8'd0, 32'd0, 1'b1);
      end else begin
        pending[pending.size() - 1].last = 1'b1;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_item;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("result with nothing waiting: %p", got));
        return;
      end
      exp_item = pending.pop_front();
      if (got.response !== exp_item.response)
        report_mismatch($sformatf("response %0d, wanted %0d", got.response,
                                  exp_item.response));
      if (got.fired_event !== exp_item.fired_event)
        report_mismatch($sformatf("fired_event %0d, wanted %0d", got.fired_event,
                                  exp_item.fired_event));
      if (got.fired_aux !== exp_item.fired_aux)
        report_mismatch($sformatf("fired_aux %h, wanted %h", got.fired_aux,
                                  exp_item.fired_aux));
      if (got.last !== exp_item.last)
        report_mismatch($sformatf("last %b, wanted %b", got.last, exp_item.last));
    endfunction

    function void report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [8:0] cfg_wdata;

  alarm_scoreboard sb;
  int  send_idle_pct;
  int  recv_idle_pct;
  bit  hold_off;
  int  cycle_count;
  logic [31:0] clock_ms;

  alarm_table_scheduler #(.SLOTS(NumSlots)) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > RunLimit) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Result side: sample at the edge, then choose ready for the next cycle.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_result(out_data);
      if (hold_off) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // The long stall on the result side, counted here in cycles.
  task automatic stall_results(int cycles);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off = 1'b0;
  endtask

  initial begin
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_wdata = 9'd256;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clock_ms = 32'd0;
    sb = new();
    sb.clear();
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_all();
  end

  // Offers one item and returns after its transfer. Valid stays high into the
  // next item unless the sender idles first.
  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
  endtask

  task automatic send_activate(logic [7:0] id, logic [30:0] dly, logic per,
                               logic [31:0] aux, logic [31:0] now);
    in_item_t it;
    it.kind = KIND_ACTIVATE;
    it.event_id = id;
    it.delay_ms = dly;
    it.periodic = per;
    it.aux_data = aux;
    it.now_ms = now;
    send_item(it);
  endtask

  task automatic send_tick(logic [31:0] now);
    in_item_t it;
    it.kind = KIND_TICK;
    it.event_id = 8'($urandom);
    it.delay_ms = 31'($urandom);
    it.periodic = 1'($urandom);
    it.aux_data = $urandom;
    it.now_ms = now;
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [8:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.id_limit = val;
  endtask

  // Mostly small ids so updates hit existing entries; the table rarely fills.
  task automatic random_item();
    int sel;
    sel = $urandom_range(99);
    if (sel < 45) begin
      clock_ms = clock_ms + $urandom_range(40);
      send_tick(($urandom_range(19) == 0) ? $urandom : clock_ms);
    end else if (sel < 85) begin
      send_activate(8'($urandom_range(9)), ($urandom_range(7) == 0) ? 31'd0 :
                    (($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(80))),
                    1'($urandom_range(1)), $urandom, clock_ms);
    end else begin
      send_activate(8'($urandom), 31'($urandom), 1'($urandom_range(1)), $urandom,
                    ($urandom_range(1) == 0) ? clock_ms : $urandom);
    end
  endtask

  task automatic run_all();
    int k;
    // Directed: extremes, wraparound, update, deactivate, zero interval.
    send_activate(8'd0, 31'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_activate(8'd255, 31'd0, 1'b0, 32'h0, 32'd100);
    send_activate(8'd7, 31'd0, 1'b1, 32'hA5A5_5A5A, 32'd100);
    send_tick(32'd99);
    send_tick(32'd100);
    send_tick(32'd100);
    send_activate(8'd7, 31'd0, 1'b1, 32'h1, 32'd100);
    send_tick(32'hFFFF_FFFF);
    send_activate(8'd0, 31'd5, 1'b0, 32'h1234_5678, 32'd200);
    send_tick(32'd205);
    write_limit(9'd1);
    send_activate(8'd1, 31'd3, 1'b0, 32'h5, 32'd0);
    write_limit(9'd256);
    // Eight new ids beside the kept id 7 entry: the last finds the table full and halts.
    for (k = 0; k < NumSlots; k++) send_activate(8'(k + 10), 31'd1, k[0], 32'(k), 32'd0);
    send_tick(32'd50);
    send_tick(32'd60);
    // Pressure: stall results while the sender keeps offering items.
    send_idle_pct = 0;
    fork
      stall_results(300);
      for (k = 0; k < 12; k++) send_tick(32'(70 + k));
    join
    drain();
    clock_ms = 32'd100;
    for (k = 0; k < 3; k++) begin
      if (k == 0) begin send_idle_pct = 29; recv_idle_pct = 84; end
      else if (k == 1) begin send_idle_pct = 84; recv_idle_pct = 29; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
      repeat (75) random_item();
      write_limit((k == 0) ? 9'd6 : 9'd256);
    end
    // More activates and a tick on the halted table, to confirm the halt is sticky.
    for (k = 0; k < NumSlots + 1; k++)
      send_activate(8'(100 + k), 31'd9, 1'b1, $urandom, clock_ms);
    send_tick(clock_ms + 100);
    send_activate(8'd3, 31'd1, 1'b0, 32'h0, 32'd0);
    drain();
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask
endmodule
`default_nettype wire
